// ===== sv/ila_pkg.sv =====
// ila_pkg: shared codes and the command/status bundles for the indexed list
// used by ila_ctrl, ila_dp and the indexed_list_append_pop top level
package ila_pkg;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [31:0] ERR_VALUE = 32'hFFFF_FFFF;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 5;
	localparam int LEN_W   = 5;
	localparam int IN_TW   = 40;
	localparam int OUT_TW  = 40;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic append_wr;
		logic rd_idx;
		logic capture;
		logic sh_start;
		logic sh_rd;
		logic sh_wr;
		logic dec_count;
		logic load_out;
	} ila_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_append;
		logic is_rw;
		logic pop_q;
		logic full;
		logic pos_ok;
		logic need_shift;
		logic shift_more;
		logic out_busy;
	} ila_stat_t;

endpackage

// ===== sv/indexed_list_append_pop.sv =====
// indexed_list_append_pop: bounded list of signed 32-bit values with append,
// pop at position and read at position; uses ila_pkg, ila_ctrl and ila_dp
//
//   channel  direction  fields (low bit up)
//   s_*      in         action[1:0] position[6:2] item_value[38:7], pad to 40
//   m_*      out        result_value[31:0] status[33:32] length[38:34], pad to 40
//
// one item at a time; an error result goes straight to the done step, append writes
// the storage, read and pop read the entry and capture it, and pop then moves each
// element above the popped one down with a read step and a write step in turn.
// reset clears the count, the sequencer state and the result valid;
// storage contents are undefined until written.
// a stalled result holds the block in its done step until m_tready takes it.
module indexed_list_append_pop
	import ila_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // action, position, item_value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // result_value, status, length
);

	ila_cmd_t          cmd;
	ila_stat_t         stat;
	logic [DATA_W-1:0] result_value;
	logic [1:0]        status;
	logic [LEN_W-1:0]  length;

	ila_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ila_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (s_tdata[1:0]),
		.position     (s_tdata[6:2]),
		.item_value   (s_tdata[38:7]),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.result_value (result_value),
		.status       (status),
		.length       (length)
	);

	assign m_tdata = {1'b0, length, status, result_value};

endmodule

// ===== sv/ila_ctrl.sv =====
// ila_ctrl: sequencer for append, read and pop with shift-down of later entries
// depends on ila_pkg for the command and status bundles
module ila_ctrl
	import ila_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ila_stat_t stat,
	output ila_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_APPEND = 7'b0000010,
		S_READ   = 7'b0000100,
		S_RWAIT  = 7'b0001000,
		S_SH_RD  = 7'b0010000,
		S_SH_WR  = 7'b0100000,
		S_DONE   = 7'b1000000
	} ila_state_t;

	ila_state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.is_append && !stat.full)
						state_d = S_APPEND;
					else if (stat.is_rw && stat.pos_ok)
						state_d = S_READ;
					else
						state_d = S_DONE;
				end
			end
			S_APPEND: begin
				cmd.append_wr = 1'b1;
				state_d       = S_DONE;
			end
			S_READ: begin
				cmd.rd_idx = 1'b1;
				state_d    = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.capture = 1'b1;
				if (stat.pop_q) begin
					if (stat.need_shift) begin
						cmd.sh_start = 1'b1;
						state_d      = S_SH_RD;
					end else begin
						cmd.dec_count = 1'b1;
						state_d       = S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_SH_RD: begin
				cmd.sh_rd = 1'b1;
				state_d   = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				if (stat.shift_more) begin
					state_d = S_SH_RD;
				end else begin
					cmd.dec_count = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ila_dp.sv =====
// ila_dp: list storage, element count, position resolution and result register
// depends on ila_pkg; driven by ila_ctrl through ila_cmd_t
module ila_dp
	import ila_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        action,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] item_value,
	input  ila_cmd_t          cmd,
	output ila_stat_t         stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] result_value,
	output logic [1:0]        status,
	output logic [LEN_W-1:0]  length
);

	localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW   = $clog2(LIST_DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [DATA_W-1:0] mem [LIST_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     ptr_q;
	logic              pop_q;
	logic [DATA_W-1:0] value_q;
	logic [1:0]        res_status_q;
	logic [DATA_W-1:0] res_value_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [1:0]        out_status_q;
	logic [LEN_W-1:0]  out_length_q;

	logic              pos_last;
	logic              full;
	logic              pos_ok;
	logic [AW-1:0]     idx_d;
	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   cnt_ext;
	logic              is_append;
	logic              is_rw;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	// position decode against the current count
	assign is_append = (action == ACT_APPEND);
	assign is_rw     = action inside {ACT_POP, ACT_READ};
	assign pos_last  = (position == {POS_W{1'b1}});
	assign full      = (count_q == CW'(LIST_DEPTH));
	assign pos_ext   = CMPW'(position[POS_W-2:0]);
	assign cnt_ext   = CMPW'(count_q);
	assign pos_ok    = (count_q != '0) &&
		(pos_last || (!position[POS_W-1] && (pos_ext < cnt_ext)));
	assign idx_d     = pos_last ? AW'(count_q - CW'(1)) : AW'(position[POS_W-2:0]);

	assign stat.is_append  = is_append;
	assign stat.is_rw      = is_rw;
	assign stat.pop_q      = pop_q;
	assign stat.full       = full;
	assign stat.pos_ok     = pos_ok;
	assign stat.need_shift = ((CW'(idx_q) + CW'(1)) < count_q);
	assign stat.shift_more = ((CW'(ptr_q) + CW'(2)) < count_q);
	assign stat.out_busy   = out_valid_q && !out_ready;

	// single write and single read port
	assign wr_en   = cmd.append_wr || cmd.sh_wr;
	assign wr_addr = cmd.sh_wr ? ptr_q : AW'(count_q);
	assign wr_data = cmd.sh_wr ? rdata_q : value_q;
	assign rd_en   = cmd.rd_idx || cmd.sh_rd;
	assign rd_addr = cmd.sh_rd ? (ptr_q + AW'(1)) : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append_wr) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.dec_count) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pop_q   <= (action == ACT_POP);
			idx_q   <= idx_d;
			value_q <= item_value;
			if (is_append) begin
				res_status_q <= full ? ST_FULL : ST_OK;
				res_value_q  <= full ? ERR_VALUE : '0;
			end else if (is_rw && pos_ok) begin
				res_status_q <= ST_OK;
				res_value_q  <= '0;
			end else begin
				res_status_q <= ST_NONE;
				res_value_q  <= ERR_VALUE;
			end
		end
		if (cmd.capture)
			res_value_q <= rdata_q;
		if (cmd.sh_start)
			ptr_q <= idx_q;
		else if (cmd.sh_wr)
			ptr_q <= ptr_q + AW'(1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_length_q <= LEN_W'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign length       = out_length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LIST_DEPTH))
		else $error("element count above list depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_count |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not drop the count by one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !out_ready))
		else $error("result loaded over a waiting result");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append_wr |-> !full)
		else $error("append written into a full list");

endmodule

// ===== test/indexed_list_append_pop_tb.sv =====
// indexed_list_append_pop_tb: self-checking bench for the bounded list with append,
// pop at position and read at position; needs ila_pkg and the indexed_list_append_pop
// rtl, predicts every result internally and runs directed, random and backpressure tests
`timescale 1ns / 1ps

module indexed_list_append_pop_tb;
	import ila_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PRINT_LIMIT = 40;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [4:0] POS_LAST = 5'h1F;

	// same bit order as m_tdata: result_value in the low bits
	typedef struct packed {
		logic [4:0]  length;
		logic [1:0]  status;
		logic [31:0] result_value;
	} list_result_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata = '0;  // action, position, item_value
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;       // result_value, status, length

	// predicted list contents and length
	logic [31:0]  list_shadow [LIST_DEPTH];
	int unsigned  list_length = 0;
	list_result_t pending_results [$];

	int unsigned gen_level = 0;  // stimulus side view of the length
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic        hold_rx = 1'b0;

	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	indexed_list_append_pop #(.LIST_DEPTH(LIST_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic list_result_t apply_list_op(logic [1:0] act, logic [4:0] pos,
			logic [31:0] val);
		list_result_t r;
		int unsigned  idx;
		bit           found;
		r.result_value = '0;
		r.status = ST_OK;
		idx = 0;
		found = 1'b0;
		case (act)
		ACT_APPEND: begin
			if (list_length >= LIST_DEPTH) begin
				r.status = ST_FULL;
				r.result_value = ERR_VALUE;
			end else begin
				list_shadow[list_length] = val;
				list_length++;
			end
		end
		ACT_POP, ACT_READ: begin
			if (list_length != 0) begin
				if (pos == POS_LAST) begin
					idx = list_length - 1;
					found = 1'b1;
				end else if (!pos[4] && pos < list_length) begin
					idx = pos;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = ST_NONE;
				r.result_value = ERR_VALUE;
			end else begin
				r.result_value = list_shadow[idx];
				if (act == ACT_POP) begin
					// later elements slide down one slot
					for (int unsigned k = idx; k + 1 < list_length; k++)
						list_shadow[k] = list_shadow[k + 1];
					list_length--;
				end
			end
		end
		default: begin
			r.status = ST_NONE;
			r.result_value = ERR_VALUE;
		end
		endcase
		r.length = list_length[4:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	// result check first, then prediction of a transaction accepted on the same edge
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[38:0];
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", got.result_value, '0);
				end else begin
					want = pending_results.pop_front();
					status_seen[want.status]++;
					if (got.result_value !== want.result_value)
						report_mismatch("result_value", got.result_value, want.result_value);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.length !== want.length)
						report_mismatch("length", got.length, want.length);
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_list_op(s_tdata[1:0], s_tdata[6:2],
					s_tdata[38:7]));
				items_sent++;
			end
		end
	end

	task automatic send_item(logic [1:0] act, logic [4:0] pos, logic [31:0] val);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, pos, act};
		do @(posedge clk); while (!s_tready);
		// track the length so positions can be aimed inside the list
		if (act == ACT_APPEND && gen_level < LIST_DEPTH)
			gen_level++;
		else if (act == ACT_POP && gen_level > 0 && (pos == POS_LAST ||
				(!pos[4] && pos < gen_level)))
			gen_level--;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
		0:       return 32'h8000_0000;
		1:       return 32'h7FFF_FFFF;
		2:       return 32'h0000_0000;
		3:       return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int unsigned append_pct);
		int unsigned r;
		logic [4:0]  pos;
		logic [1:0]  act;
		r = $urandom_range(99);
		if (r < append_pct) begin
			send_item(ACT_APPEND, 5'($urandom), pick_value());
		end else begin
			if ($urandom_range(99) < 5)
				act = ACT_UNUSED;
			else
				act = ($urandom_range(99) < 55) ? ACT_POP : ACT_READ;
			r = $urandom_range(99);
			if (r < 15)
				pos = POS_LAST;
			else if (r < 80 && gen_level > 0)
				pos = 5'($urandom_range(gen_level - 1));
			else
				pos = 5'($urandom);
			send_item(act, pos, $urandom);
		end
	endtask

	// alternate filling and draining so the length sweeps empty to full
	task automatic run_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_random(((i / 48) % 2 == 0) ? 65 : 25);
	endtask

	task automatic test_empty_list();
		send_item(ACT_POP, 5'd0, 32'h1234_5678);
		send_item(ACT_READ, POS_LAST, 32'h0);
		wait_drain();
	endtask

	task automatic test_fill_to_overflow();
		logic [31:0] val;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			case (i)
			0:       val = 32'h8000_0000;
			1:       val = 32'h7FFF_FFFF;
			2:       val = 32'h0000_0000;
			3:       val = 32'hFFFF_FFFF;
			4:       val = 32'hAAAA_AAAA;
			5:       val = 32'h5555_5555;
			default: val = 32'h0C0F_FEE0 + i;
			endcase
			send_item(ACT_APPEND, 5'd0, val);
		end
		// one more append on a full list gets dropped
		send_item(ACT_APPEND, 5'd0, 32'hDEAD_BEEF);
		wait_drain();
	endtask

	task automatic test_positions();
		send_item(ACT_READ, POS_LAST, 32'h0);
		send_item(ACT_READ, 5'h10, 32'h0);   // most negative position
		send_item(ACT_POP, 5'd15, 32'h0);    // length-1 on a full list
		send_item(ACT_POP, POS_LAST, 32'h0);
		send_item(ACT_POP, 5'd0, 32'h0);     // whole list shifts down
		send_item(ACT_READ, 5'h1E, 32'h0);   // -2 is out of range
		send_item(ACT_READ, 5'd14, 32'h0);   // past the end
		send_item(ACT_UNUSED, 5'd1, 32'hFFFF_FFFF);
		wait_drain();
	endtask

	task automatic test_random_phases();
		int unsigned idle_mix [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{34, 34}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p][0];
			stall_pct <= idle_mix[p][1];
			run_random(460);
			wait_drain();
		end
	endtask

	task automatic hold_receiver(int unsigned cycles);
		hold_rx <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_rx <= 1'b0;
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct <= 0;
		fork
			hold_receiver(400);
		join_none
		run_random(60);
		wait_drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_overflow();
		test_positions();
		test_random_phases();
		test_backpressure();
		$display("%0d list transactions and %0d results in %0d cycles", items_sent,
			results_checked, cycle_count);
		$display("status ok %0d, no such element %0d, list full %0d, %0d errors",
			status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_FULL], errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
